// ===== design/moma_pkg.sv =====
// shared types, constants and decode helpers for the midi out message assembler
package moma_pkg;

    localparam logic [7:0] MIDI_EOX = 8'hF7;
    localparam logic [7:0] MIDI_SOX = 8'hF0;
    localparam logic [4:0] REALTIME_PREFIX = 5'b11111;

    // configuration register indexes
    localparam logic CFG_KEEP_STATUS   = 1'b0;
    localparam logic CFG_MAX_SYSEX_LEN = 1'b1;

    localparam logic [15:0] MAX_SYSEX_LEN_RESET = 16'd1024;

    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_SYSEX = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] msg_length;
        logic       last;
    } moma_result_t;

    // number of parameter bytes that follow a status byte
    function automatic logic [1:0] param_count(input logic [7:0] st);
        logic [1:0] n;
        n = 2'd0;
        unique case (st[7:4])
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: n = 2'd2;
            4'hC, 4'hD:                   n = 2'd1;
            default:
            begin
                if (st[3])
                begin
                    n = 2'd0;
                end
                else
                begin
                    unique case (st[2:0])
                        3'd0, 3'd6, 3'd7: n = 2'd0;
                        3'd1, 3'd3, 3'd5: n = 2'd1;
                        default:          n = 2'd2;
                    endcase
                end
            end
        endcase
        return n;
    endfunction

    function automatic moma_result_t short_msg(input logic [7:0] b0);
        moma_result_t r;
        r = '0;
        r.kind       = KIND_SHORT;
        r.byte0      = b0;
        r.msg_length = 2'd1;
        return r;
    endfunction

    function automatic moma_result_t sysex_msg(input logic [7:0] b0, input logic is_last);
        moma_result_t r;
        r = '0;
        r.kind  = KIND_SYSEX;
        r.byte0 = b0;
        r.last  = is_last;
        return r;
    endfunction

endpackage

// ===== design/moma_if.sv =====
// handshake channels for raw midi bytes and assembled messages
interface moma_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface moma_msg_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] msg_length;
    logic       last;

    modport source (output valid, output kind, output byte0, output byte1, output byte2,
                    output msg_length, output last, input ready);
    modport sink   (input valid, input kind, input byte0, input byte1, input byte2,
                    input msg_length, input last, output ready);
endinterface

// ===== design/midi_out_message_assembler.sv =====
// top level: midi running status message assembler with sysex streaming
//
// raw midi bytes arrive on the raw channel, one byte per transfer; assembled
// messages leave on the msg channel, one result per transfer. a short message
// carries 1 to 3 bytes with msg_length set; a sysex byte has kind set and
// msg_length 0, and the eox that closes a sysex run has last set. the user
// writes configuration (keep_status, max_sysex_len) through cfg_we, cfg_index
// and cfg_data only while the block is idle; the block does not enforce this.
//
// throughput: one raw byte per cycle while the result queue has room. a byte
// is held in the input register, then its results go to the result queue.
// a byte that closes a sysex run can make two results (eox, then the new
// status or sysex start); they leave one after the other, eox first.
// the rate is set by the four-entry result queue: a byte is processed only
// while the queue holds two or fewer entries, so a stalled receiver fills the
// queue and then the input register, after which raw.ready drops. nothing is
// lost or reordered while stalled.
// reset: no status, no sysex run, empty queue, keep_status 1, limit 1024.
module midi_out_message_assembler
    import moma_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    moma_byte_if.sink     raw,
    moma_msg_if.source    msg,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [15:0]   cfg_data
);

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // configuration registers
    logic        keep_status_reg;
    logic [15:0] max_sysex_len_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // parser state
    logic [7:0]  msg_bytes_reg [3];
    logic [7:0]  msg_bytes_next [3];
    logic [3:0]  msg_fill_reg, msg_fill_next;
    logic [1:0]  status_params_reg, status_params_next;
    logic [1:0]  params_left_reg, params_left_next;
    logic        in_sysex_reg, in_sysex_next;
    logic [15:0] sysex_count_reg, sysex_count_next;

    // result queue
    moma_result_t         queue_reg [QDepth];
    logic [QPtrW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QCntW-1:0]     count_reg, count_next;

    logic                 advance;
    logic                 pop;
    logic [1:0]           n_res;
    moma_result_t         res0, res1;

    // working signals of the parse step
    logic                 eox_hit;
    logic                 other_vld;
    moma_result_t         other_res;
    logic [1:0]           n_par;
    logic [1:0]           send_len;
    moma_result_t         send_res;

    // a byte is processed when the queue can take two more results
    assign advance   = in_valid_reg && (count_reg <= QCntW'(QDepth - 2));
    assign raw.ready = !in_valid_reg || advance;
    assign pop       = msg.valid && msg.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_status_reg   <= 1'b1;
            max_sysex_len_reg <= MAX_SYSEX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEEP_STATUS:   keep_status_reg   <= cfg_data[0];
                CFG_MAX_SYSEX_LEN: max_sysex_len_reg <= cfg_data;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (raw.ready)
        begin
            in_valid_reg <= raw.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw.valid && raw.ready)
        begin
            in_byte_reg <= raw.in_byte;
        end
    end

    // parse step: next state and up to two results for the registered byte
    always_comb
    begin
        msg_bytes_next     = msg_bytes_reg;
        msg_fill_next      = msg_fill_reg;
        status_params_next = status_params_reg;
        params_left_next   = params_left_reg;
        in_sysex_next      = in_sysex_reg;
        sysex_count_next   = sysex_count_reg;
        eox_hit            = 1'b0;
        other_vld          = 1'b0;
        other_res          = '0;
        n_par              = param_count(in_byte_reg);
        send_len           = 2'd0;
        send_res           = '0;

        if (!in_byte_reg[7])
        begin
            // data byte
            if (in_sysex_reg)
            begin
                if (sysex_count_reg < max_sysex_len_reg)
                begin
                    sysex_count_next = sysex_count_reg + 16'd1;
                    other_vld        = 1'b1;
                    other_res        = sysex_msg(in_byte_reg, 1'b0);
                end
            end
            else if (status_params_reg != 2'd0)
            begin
                // running status restarts the parameter count
                if (params_left_reg == 2'd0)
                begin
                    params_left_next = status_params_reg - 2'd1;
                end
                else
                begin
                    params_left_next = params_left_reg - 2'd1;
                end

                if (msg_fill_reg < 4'd8)
                begin
                    if (msg_fill_reg < 4'd3)
                    begin
                        msg_bytes_next[msg_fill_reg[1:0]] = in_byte_reg;
                    end
                    msg_fill_next = msg_fill_reg + 4'd1;
                end

                if (params_left_next == 2'd0)
                begin
                    send_len            = (msg_fill_next >= 4'd3) ? 2'd3 : msg_fill_next[1:0];
                    send_res.kind       = KIND_SHORT;
                    send_res.byte0      = msg_bytes_next[0];
                    send_res.byte1      = (send_len >= 2'd2) ? msg_bytes_next[1] : 8'd0;
                    send_res.byte2      = (send_len == 2'd3) ? msg_bytes_next[2] : 8'd0;
                    send_res.msg_length = send_len;
                    send_res.last       = 1'b0;
                    other_vld           = 1'b1;
                    other_res           = send_res;
                    msg_fill_next       = {3'b000, keep_status_reg};
                end
            end
        end
        else if (in_byte_reg[7:3] == REALTIME_PREFIX)
        begin
            // real-time bytes pass straight through
            other_vld = 1'b1;
            other_res = short_msg(in_byte_reg);
        end
        else
        begin
            // any other status byte closes an open sysex run
            if (in_sysex_reg)
            begin
                eox_hit       = 1'b1;
                in_sysex_next = 1'b0;
            end

            if (!(in_sysex_reg && (in_byte_reg == MIDI_EOX)))
            begin
                if (in_byte_reg == MIDI_SOX)
                begin
                    in_sysex_next = 1'b1;
                    if (max_sysex_len_reg != 16'd0)
                    begin
                        sysex_count_next = 16'd1;
                        other_vld        = 1'b1;
                        other_res        = sysex_msg(in_byte_reg, 1'b0);
                    end
                    else
                    begin
                        sysex_count_next = 16'd0;
                    end
                end
                else if (n_par != 2'd0)
                begin
                    msg_bytes_next[0]  = in_byte_reg;
                    msg_fill_next      = 4'd1;
                    status_params_next = n_par;
                    params_left_next   = n_par;
                end
                else
                begin
                    other_vld = 1'b1;
                    other_res = short_msg(in_byte_reg);
                end
            end
        end
    end

    // order the results: the eox always goes first
    always_comb
    begin
        res0  = '0;
        res1  = '0;
        n_res = 2'd0;
        if (eox_hit)
        begin
            res0  = sysex_msg(MIDI_EOX, 1'b1);
            res1  = other_res;
            n_res = other_vld ? 2'd2 : 2'd1;
        end
        else if (other_vld)
        begin
            res0  = other_res;
            n_res = 2'd1;
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_bytes_reg[0]  <= 8'd0;
            msg_bytes_reg[1]  <= 8'd0;
            msg_bytes_reg[2]  <= 8'd0;
            msg_fill_reg      <= 4'd0;
            status_params_reg <= 2'd0;
            params_left_reg   <= 2'd0;
            in_sysex_reg      <= 1'b0;
            sysex_count_reg   <= 16'd0;
        end
        else if (advance)
        begin
            msg_bytes_reg[0]  <= msg_bytes_next[0];
            msg_bytes_reg[1]  <= msg_bytes_next[1];
            msg_bytes_reg[2]  <= msg_bytes_next[2];
            msg_fill_reg      <= msg_fill_next;
            status_params_reg <= status_params_next;
            params_left_reg   <= params_left_next;
            in_sysex_reg      <= in_sysex_next;
            sysex_count_reg   <= sysex_count_next;
        end
    end

    // result queue
    assign count_next = count_reg + QCntW'(advance ? n_res : 2'd0) - QCntW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (advance)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPtrW'(n_res);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPtrW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && (n_res != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= res0;
            if (n_res == 2'd2)
            begin
                queue_reg[wr_ptr_reg + QPtrW'(1)] <= res1;
            end
        end
    end

    assign msg.valid      = (count_reg != '0);
    assign msg.kind       = queue_reg[rd_ptr_reg].kind;
    assign msg.byte0      = queue_reg[rd_ptr_reg].byte0;
    assign msg.byte1      = queue_reg[rd_ptr_reg].byte1;
    assign msg.byte2      = queue_reg[rd_ptr_reg].byte2;
    assign msg.msg_length = queue_reg[rd_ptr_reg].msg_length;
    assign msg.last       = queue_reg[rd_ptr_reg].last;

`ifndef SYNTHESIS
    // queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCntW'(QDepth))
        else $error("result queue overflow");

    // a pending parameter count implies a known status
    a_params_status: assert property (@(posedge clk) disable iff (!rst_n)
        (params_left_reg != 2'd0) |-> (status_params_reg != 2'd0))
        else $error("parameters pending without status");

    // real-time bytes leave the parser state untouched
    a_realtime_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_byte_reg[7:3] == REALTIME_PREFIX)) |=>
            ($stable(msg_fill_reg) && $stable(in_sysex_reg) && $stable(sysex_count_reg)
             && $stable(params_left_reg)))
        else $error("real-time byte changed parser state");

    // message fill saturates at eight
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        msg_fill_reg <= 4'd8)
        else $error("message fill out of range");
`endif

endmodule

// ===== tb/sv/tb_midi_out_message_assembler.sv =====
// self-checking testbench for the midi out message assembler
`timescale 1ns / 100ps

module tb_midi_out_message_assembler
    import moma_pkg::*;
();

    // no transfer on either channel for this many cycles ends the run
    localparam int STUCK_LIMIT = 2000;
    // long receiver hold-off used to fill the result queue
    localparam int HOLD_CYCLES = 300;
    // quiet cycles after the last expected message before idle actions
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES = 20;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [15:0] cfg_data;

    moma_byte_if raw_ch ();
    moma_msg_if  msg_ch ();

    midi_out_message_assembler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw       (raw_ch.sink),
        .msg       (msg_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // assembler state as the testbench predicts it
    logic        keep_running;
    logic [15:0] sysex_limit;
    logic [7:0]  asm_buf [3];
    logic [3:0]  asm_fill;
    logic [1:0]  running_params;
    logic [1:0]  params_owed;
    logic        sysex_open;
    logic [15:0] sysex_taken;

    // messages still owed by the block, oldest first
    moma_result_t pending_msgs[$];

    int err_count;
    int handled_bytes;   // raw bytes that have an effect on the block
    int stuck_cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    bit hold_request;

    // clock, 4 ns period
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // every block input starts at a known value
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_KEEP_STATUS;
        cfg_data       = '0;
        raw_ch.valid   = 1'b0;
        raw_ch.in_byte = '0;
        msg_ch.ready   = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // data bytes that follow a status byte; realtime and the
    // parameterless system common bytes take none
    function automatic int param_bytes(input logic [7:0] st);
        case (st[7:4])
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: return 2;
            4'hC, 4'hD: return 1;
            default:
            begin
                case (st[3:0])
                    4'h1, 4'h3, 4'h5: return 1;
                    4'h2, 4'h4: return 2;
                    default: return 0;
                endcase
            end
        endcase
    endfunction

    function automatic moma_result_t make_msg(input logic kind, input logic [7:0] b0,
                                              input logic [7:0] b1, input logic [7:0] b2,
                                              input logic [1:0] len, input logic is_last);
        moma_result_t r;
        r.kind       = kind;
        r.byte0      = b0;
        r.byte1      = b1;
        r.byte2      = b2;
        r.msg_length = len;
        r.last       = is_last;
        return r;
    endfunction

    task automatic predict_reset();
        keep_running   = 1'b1;
        sysex_limit    = MAX_SYSEX_LEN_RESET;
        asm_buf[0]     = '0;
        asm_fill       = '0;
        running_params = '0;
        params_owed    = '0;
        sysex_open     = 1'b0;
        sysex_taken    = '0;
    endtask

    // one sysex byte goes out only while the run is under its limit
    task automatic emit_sysex(input logic [7:0] b);
        if (sysex_taken < sysex_limit)
        begin
            sysex_taken++;
            pending_msgs.push_back(make_msg(KIND_SYSEX, b, 8'h00, 8'h00, 2'd0, 1'b0));
        end
    endtask

    // buffer keeps three bytes, fill count saturates at eight
    task automatic buffer_byte(input logic [7:0] b);
        if (asm_fill < 4'd8)
        begin
            if (asm_fill < 4'd3)
            begin
                asm_buf[asm_fill] = b;
            end
            asm_fill++;
        end
    endtask

    // expected messages caused by one accepted raw byte
    task automatic assemble_expected(input logic [7:0] b);
        logic [1:0] len;
        logic [7:0] b1;
        logic [7:0] b2;
        int n;
        if (!b[7])
        begin
            if (sysex_open)
            begin
                handled_bytes++;
                emit_sysex(b);
            end
            else if (running_params != 2'd0)
            begin
                // running status reloads the count for each new message
                handled_bytes++;
                if (params_owed == 2'd0)
                begin
                    params_owed = running_params - 2'd1;
                end
                else
                begin
                    params_owed--;
                end
                buffer_byte(b);
                if (params_owed == 2'd0)
                begin
                    len = (asm_fill >= 4'd3) ? 2'd3 : asm_fill[1:0];
                    b1  = (len >= 2'd2) ? asm_buf[1] : 8'h00;
                    b2  = (len == 2'd3) ? asm_buf[2] : 8'h00;
                    pending_msgs.push_back(make_msg(KIND_SHORT, asm_buf[0], b1, b2, len, 1'b0));
                    asm_fill = {3'b000, keep_running};
                end
            end
            // data with no status seen yet is dropped
            return;
        end
        handled_bytes++;
        if (b[7:3] == REALTIME_PREFIX)
        begin
            // realtime passes straight through and touches nothing
            pending_msgs.push_back(make_msg(KIND_SHORT, b, 8'h00, 8'h00, 2'd1, 1'b0));
            return;
        end
        if (sysex_open)
        begin
            // any other status closes the sysex run with an eox
            pending_msgs.push_back(make_msg(KIND_SYSEX, MIDI_EOX, 8'h00, 8'h00, 2'd0, 1'b1));
            sysex_open = 1'b0;
            if (b == MIDI_EOX)
            begin
                return;
            end
        end
        if (b == MIDI_SOX)
        begin
            sysex_open  = 1'b1;
            sysex_taken = '0;
            emit_sysex(b);
            return;
        end
        n = param_bytes(b);
        if (n > 0)
        begin
            asm_fill       = '0;
            running_params = 2'(n);
            params_owed    = 2'(n);
            buffer_byte(b);
        end
        else
        begin
            // parameterless system common leaves running status alone
            pending_msgs.push_back(make_msg(KIND_SHORT, b, 8'h00, 8'h00, 2'd1, 1'b0));
        end
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // called just after a falling edge; returns just after a falling edge
    // with valid still high so back-to-back transfers need no extra step
    task automatic send_raw_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            raw_ch.valid <= 1'b0;
            @(negedge clk);
        end
        raw_ch.valid   <= 1'b1;
        raw_ch.in_byte <= b;
        @(posedge clk);
        while (!raw_ch.ready)
        begin
            @(posedge clk);
        end
        assemble_expected(b);
        @(negedge clk);
    endtask

    task automatic send_seq(input logic [7:0] seq[]);
        foreach (seq[i])
        begin
            send_raw_byte(seq[i]);
        end
    endtask

    // drop valid, wait for every owed message, then let the pipe drain
    // since bytes that make no message may still be in flight
    task automatic settle();
        raw_ch.valid <= 1'b0;
        while (pending_msgs.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write, only while the block is idle
    task automatic write_cfg(input logic index, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (index == CFG_KEEP_STATUS)
        begin
            keep_running = value[0];
        end
        else
        begin
            sysex_limit = value;
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            msg_ch.ready <= 1'b0;
        end
        else
        begin
            msg_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
            err_count++;
        end
    endtask

    // each message transfer is matched against the oldest expectation
    always @(posedge clk)
    begin : msg_monitor
        moma_result_t want;
        if (rst_n && msg_ch.valid && msg_ch.ready)
        begin
            if (pending_msgs.size() == 0)
            begin
                $display("%0t: unexpected message, expected none, actual %0d %02h %02h %02h %0d %0d",
                         $time, msg_ch.kind, msg_ch.byte0, msg_ch.byte1, msg_ch.byte2,
                         msg_ch.msg_length, msg_ch.last);
                err_count++;
            end
            else
            begin
                want = pending_msgs.pop_front();
                check_field("kind", 8'(want.kind), 8'(msg_ch.kind));
                check_field("byte0", want.byte0, msg_ch.byte0);
                check_field("byte1", want.byte1, msg_ch.byte1);
                check_field("byte2", want.byte2, msg_ch.byte2);
                check_field("msg_length", 8'(want.msg_length), 8'(msg_ch.msg_length));
                check_field("last", 8'(want.last), 8'(msg_ch.last));
            end
        end
    end

    // watchdog: cycles in which nothing transfers on either channel
    always @(posedge clk)
    begin
        if ((raw_ch.valid && raw_ch.ready) || (msg_ch.valid && msg_ch.ready))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [7:0] rand_realtime();
        return {REALTIME_PREFIX, 3'($urandom_range(7))};
    endfunction

    // data bytes with the odd realtime byte slipped in between
    task automatic send_data_bytes(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(19) == 0)
            begin
                send_raw_byte(rand_realtime());
            end
            send_raw_byte(8'($urandom_range(127)));
        end
    endtask

    // mostly well-formed traffic with random content, some broken
    // messages and some plain noise
    task automatic random_traffic(input int target);
        int start;
        int pick;
        int n;
        int reps;
        logic [7:0] st;
        start = handled_bytes;
        while (handled_bytes - start < target)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                // channel message, then a few running status repeats
                st = {1'b1, 3'($urandom_range(6)), 4'($urandom_range(15))};
                send_raw_byte(st);
                reps = $urandom_range(3);
                for (int r = 0; r <= reps; r++)
                begin
                    n = param_bytes(st);
                    if ($urandom_range(9) == 0)
                    begin
                        n = $urandom_range(3);
                    end
                    send_data_bytes(n);
                end
            end
            else if (pick < 58)
            begin
                // system common, defined or not
                st = {5'b11110, 3'($urandom_range(1, 7))};
                send_raw_byte(st);
                send_data_bytes(param_bytes(st));
            end
            else if (pick < 73)
            begin
                // sysex run, closed by eox, by another status or left open
                send_raw_byte(MIDI_SOX);
                send_data_bytes($urandom_range(10));
                case ($urandom_range(3))
                    0, 1: send_raw_byte(MIDI_EOX);
                    2: send_raw_byte({1'b1, 7'($urandom_range(127))});
                    default: ;
                endcase
            end
            else if (pick < 83)
            begin
                send_raw_byte(rand_realtime());
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                begin
                    send_raw_byte(8'($urandom_range(255)));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values: data before status, running status, realtime in the
    // middle of a message, all system common classes incl. undefined ones
    task automatic test_running_status();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        send_seq('{8'h05, 8'h90, 8'h3C, 8'h7F, 8'h40, 8'hFF, 8'h00, 8'hC5, 8'h00,
                   8'hF6, 8'hF1, 8'h7F, 8'hF4, 8'h01, 8'h02, 8'hF5, 8'h03, 8'hF7});
        settle();
    endtask

    // sysex closed by eox, by a channel status and by a new sysex start,
    // with realtime inside the run
    task automatic test_sysex_close();
        send_seq('{8'hF0, 8'h01, 8'h7F, 8'hF7, 8'hF0, 8'h11, 8'hFE, 8'h90,
                   8'h22, 8'h33, 8'hF0, 8'hF0, 8'hF7});
        settle();
    endtask

    // buffer cleared after each send, sysex limit at one so only the sysex
    // start goes out, the data bytes are dropped but the eox still shows up
    task automatic test_cleared_status_tiny_sysex();
        write_cfg(CFG_KEEP_STATUS, 16'd0);
        write_cfg(CFG_MAX_SYSEX_LEN, 16'd1);
        send_seq('{8'hB0, 8'h07, 8'h64, 8'h08, 8'h10, 8'hF0, 8'h01, 8'h02, 8'hF7,
                   8'hF0, 8'h80, 8'h01, 8'h02});
        settle();
    endtask

    // receiver holds off long enough for the result queue to fill and
    // raw.ready to drop while the sender keeps offering bytes
    task automatic test_backpressure();
        write_cfg(CFG_KEEP_STATUS, 16'd1);
        write_cfg(CFG_MAX_SYSEX_LEN, 16'hFFFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        random_traffic(60);
        settle();
    endtask

    // random traffic under three idling patterns and config settings
    task automatic test_random_traffic();
        write_cfg(CFG_KEEP_STATUS, 16'd1);
        write_cfg(CFG_MAX_SYSEX_LEN, 16'($urandom_range(2, 6)));
        send_idle_pct = 30;
        recv_idle_pct = 51;
        random_traffic(220);
        settle();

        write_cfg(CFG_KEEP_STATUS, 16'd0);
        write_cfg(CFG_MAX_SYSEX_LEN, 16'hFFFF);
        send_idle_pct = 51;
        recv_idle_pct = 30;
        random_traffic(220);
        settle();

        write_cfg(CFG_KEEP_STATUS, 16'($urandom_range(1)));
        write_cfg(CFG_MAX_SYSEX_LEN, 16'($urandom_range(1, 12)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(220);
        settle();
    endtask

    initial
    begin
        err_count     = 0;
        handled_bytes = 0;
        stuck_cycles  = 0;
        hold_left     = 0;
        hold_request  = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        predict_reset();

        // single reset at the start of the run
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_running_status();
        test_sysex_close();
        test_cleared_status_tiny_sysex();
        test_backpressure();
        test_random_traffic();

        // settle leaves nothing owed; a short tail catches stray messages
        repeat (TAIL_CYCLES) @(negedge clk);
        if (err_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
